FILE: rtl/cau_pkg.sv
// Shared types, command and status codes for the complex arithmetic unit.
// Used by every module under rtl/; depends on nothing else.
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_BITS_MAX = 30;
  // Quotient bits below the overflow bit; the cell chain has QB+1 cells.
  localparam int QB = 32;
  // Remainder width: covers mag << FRAC_BITS_MAX and den << QB.
  localparam int RW = 97;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_INC = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DZ = 2'd1;
  localparam logic [1:0] ST_OV = 2'd2;

  // One divide lane: running remainder, quotient bits (top bit = overflow), sign.
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB:0]   q;
    logic          neg;
  } div_lane_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
    logic [63:0] den;
    div_lane_t   lre;
    div_lane_t   lim;
  } item_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ov;
  } sat_t;

  function automatic sat_t sat32(input logic signed [66:0] v);
    sat_t r;
    if (v > 67'sh7FFFFFFF) begin
      r.val = 32'h7FFF_FFFF;
      r.ov  = 1'b1;
    end else if (v < -67'sh80000000) begin
      r.val = 32'h8000_0000;
      r.ov  = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ov  = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/cau_front.sv
// Front pipeline: operand capture, products, sums, rounding and dividend setup.
// Depends on cau_pkg; feeds the divide cell chain.
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_cmd,
  input  logic signed [31:0]  in_a_re,
  input  logic signed [31:0]  in_a_im,
  input  logic signed [31:0]  in_b_re,
  input  logic signed [31:0]  in_b_im,
  output logic                out_valid,
  input  logic                out_ready,
  output cau_pkg::item_t      out_item
);
  import cau_pkg::*;

  localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [66:0] ONE  = 67'sd1 <<< FRAC_BITS;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || out_ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: capture
  logic [2:0]         cmd1_r;
  logic signed [31:0] ar1_r, ai1_r, br1_r, bi1_r;

  // stage 2: products and the simple commands
  logic [2:0]         cmd2_r;
  logic signed [63:0] prr2_r, pii2_r, pri2_r, pir2_r, pbb2_r, pcc2_r;
  logic [31:0]        re2_r, im2_r;
  logic [1:0]         st2_r;
  logic [31:0]        re2_nxt, im2_nxt;
  logic [1:0]         st2_nxt;

  // stage 3: sums
  logic [2:0]         cmd3_r;
  logic signed [66:0] nre3_r, nim3_r;
  logic [63:0]        den3_r;
  logic [31:0]        re3_r, im3_r;
  logic [1:0]         st3_r;
  logic signed [66:0] nre3_nxt, nim3_nxt;

  // stage 4: multiply rounding, divide sign/magnitude
  logic [2:0]         cmd4_r;
  logic [63:0]        den4_r;
  logic [63:0]        mre4_r, mim4_r;
  logic               nre4_r, nim4_r;
  logic [31:0]        re4_r, im4_r;
  logic [1:0]         st4_r;
  logic [31:0]        re4_nxt, im4_nxt;
  logic [1:0]         st4_nxt;
  logic [66:0]        negre, negim;

  // stage 5: dividend
  item_t              it5_r;
  item_t              it5_nxt;

  always_comb begin
    sat_t sr, si;
    sr = '0;
    si = '0;
    re2_nxt = '0;
    im2_nxt = '0;
    st2_nxt = ST_OK;
    case (cmd1_r)
      CMD_ADD: begin
        sr = sat32(67'(ar1_r) + 67'(br1_r));
        si = sat32(67'(ai1_r) + 67'(bi1_r));
      end
      CMD_SUB: begin
        sr = sat32(67'(ar1_r) - 67'(br1_r));
        si = sat32(67'(ai1_r) - 67'(bi1_r));
      end
      CMD_INC: begin
        sr = sat32(67'(ar1_r) + ONE);
        si = sat32(67'(ai1_r) + ONE);
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    re2_nxt = sr.val;
    im2_nxt = si.val;
    st2_nxt = (sr.ov || si.ov) ? ST_OV : ST_OK;
  end

  always_comb begin
    if (cmd2_r == CMD_MUL) begin
      nre3_nxt = 67'(prr2_r) - 67'(pii2_r) + HALF;
      nim3_nxt = 67'(pri2_r) + 67'(pir2_r) + HALF;
    end else begin
      nre3_nxt = 67'(prr2_r) + 67'(pii2_r);
      nim3_nxt = 67'(pir2_r) - 67'(pri2_r);
    end
  end

  always_comb begin
    sat_t sr, si;
    sr = sat32(nre3_r >>> FRAC_BITS);
    si = sat32(nim3_r >>> FRAC_BITS);
    negre = -nre3_r;
    negim = -nim3_r;
    if (cmd3_r == CMD_MUL) begin
      re4_nxt = sr.val;
      im4_nxt = si.val;
      st4_nxt = (sr.ov || si.ov) ? ST_OV : ST_OK;
    end else begin
      re4_nxt = re3_r;
      im4_nxt = im3_r;
      st4_nxt = st3_r;
    end
  end

  always_comb begin
    it5_nxt         = '0;
    it5_nxt.cmd     = cmd4_r;
    it5_nxt.re      = re4_r;
    it5_nxt.im      = im4_r;
    it5_nxt.st      = st4_r;
    it5_nxt.den     = den4_r;
    it5_nxt.lre.neg = nre4_r;
    it5_nxt.lim.neg = nim4_r;
    it5_nxt.lre.rem = (RW'(mre4_r) << FRAC_BITS) + RW'(den4_r >> 1);
    it5_nxt.lim.rem = (RW'(mim4_r) << FRAC_BITS) + RW'(den4_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      cmd1_r <= in_cmd;
      ar1_r  <= in_a_re;
      ai1_r  <= in_a_im;
      br1_r  <= in_b_re;
      bi1_r  <= in_b_im;
    end
    if (rdy2 && v1_r) begin
      cmd2_r <= cmd1_r;
      prr2_r <= ar1_r * br1_r;
      pii2_r <= ai1_r * bi1_r;
      pri2_r <= ar1_r * bi1_r;
      pir2_r <= ai1_r * br1_r;
      pbb2_r <= br1_r * br1_r;
      pcc2_r <= bi1_r * bi1_r;
      re2_r  <= re2_nxt;
      im2_r  <= im2_nxt;
      st2_r  <= st2_nxt;
    end
    if (rdy3 && v2_r) begin
      cmd3_r <= cmd2_r;
      nre3_r <= nre3_nxt;
      nim3_r <= nim3_nxt;
      den3_r <= $unsigned(pbb2_r) + $unsigned(pcc2_r);
      re3_r  <= re2_r;
      im3_r  <= im2_r;
      st3_r  <= st2_r;
    end
    if (rdy4 && v3_r) begin
      cmd4_r <= cmd3_r;
      den4_r <= den3_r;
      nre4_r <= nre3_r[66];
      nim4_r <= nim3_r[66];
      mre4_r <= nre3_r[66] ? negre[63:0] : nre3_r[63:0];
      mim4_r <= nim3_r[66] ? negim[63:0] : nim3_r[63:0];
      re4_r  <= re4_nxt;
      im4_r  <= im4_nxt;
      st4_r  <= st4_nxt;
    end
    if (rdy5 && v4_r) begin
      it5_r <= it5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_item  = it5_r;

endmodule

FILE: rtl/cau_div_cell.sv
// One restoring-division cell: resolves quotient bit SHIFT for both lanes.
// Depends on cau_pkg; chained QB+1 times in the top level.
module cau_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cau_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output cau_pkg::item_t out_item
);
  import cau_pkg::*;

  logic          v_r;
  item_t         it_r;
  item_t         it_nxt;
  logic [RW-1:0] dsh;

  assign in_ready = !v_r || out_ready;
  assign dsh      = RW'(in_item.den) << SHIFT;

  always_comb begin
    it_nxt = in_item;
    if (in_item.lre.rem >= dsh) begin
      it_nxt.lre.rem      = in_item.lre.rem - dsh;
      it_nxt.lre.q[SHIFT] = 1'b1;
    end
    if (in_item.lim.rem >= dsh) begin
      it_nxt.lim.rem      = in_item.lim.rem - dsh;
      it_nxt.lim.q[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      it_r <= it_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = it_r;

endmodule

FILE: rtl/cau_back.sv
// Result stage: divide sign, saturation and zero-divisor handling; output register.
// Depends on cau_pkg; fed by the last divide cell.
module cau_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cau_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_re,
  output logic [31:0]    out_im,
  output logic [1:0]     out_st
);
  import cau_pkg::*;

  logic        v_r;
  logic [31:0] re_r, im_r, re_nxt, im_nxt;
  logic [1:0]  st_r, st_nxt;
  sat_t        dre, dim;

  function automatic sat_t fin(input div_lane_t l);
    sat_t        r;
    logic [32:0] lim;
    lim = l.neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    if (l.q[QB] || {1'b0, l.q[QB-1:0]} > lim) begin
      r.val = l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      r.ov  = 1'b1;
    end else begin
      r.val = l.neg ? (32'd0 - l.q[QB-1:0]) : l.q[QB-1:0];
      r.ov  = 1'b0;
    end
    return r;
  endfunction

  assign in_ready = !v_r || out_ready;

  always_comb begin
    dre    = fin(in_item.lre);
    dim    = fin(in_item.lim);
    re_nxt = in_item.re;
    im_nxt = in_item.im;
    st_nxt = in_item.st;
    if (in_item.cmd == CMD_DIV) begin
      if (in_item.den == 64'd0) begin
        re_nxt = '0;
        im_nxt = '0;
        st_nxt = ST_DZ;
      end else begin
        re_nxt = dre.val;
        im_nxt = dim.val;
        st_nxt = (dre.ov || dim.ov) ? ST_OV : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_re    = re_r;
  assign out_im    = im_r;
  assign out_st    = st_r;

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// Complex add/sub/mul/div/increment unit on signed fixed-point operands.
// Depends on cau_pkg, cau_front, cau_div_cell and cau_back.
//
// Usage:
//   Input stream (in_*): one transaction carries a command and operands a, b.
//   Output stream (out_*): one transaction per input, in order, with res_re,
//   res_im and a status (0 ok, 1 zero divisor, 2 a part saturated).
//   Each transaction passes 5 front stages (capture, 32x32 products,
//   sums, rounding/sign, dividend), 33 divide cells that each resolve one
//   quotient bit for both parts, and the output register. Every command
//   takes the same path, so results leave in order.
//   Throughput is one transaction per cycle while out_tready stays high; the
//   cell chain is fully pipelined and each stage holds one transaction.
//   When the receiver stalls, results pile up in the stages: a stage takes a
//   new transaction whenever it is empty or its successor moves, so input is
//   still accepted until the whole chain is full.
//   Reset (rst_n low, synchronous) empties every stage; nothing else is kept.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] command, [34:3] a_re, [66:35] a_im, [98:67] b_re, [130:99] b_im
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] res_re, [63:32] res_im, [65:64] status
  output logic [71:0]  out_tdata
);
  import cau_pkg::*;

  localparam int NC = QB + 1;

  logic  v_c   [NC+1];
  logic  r_c   [NC+1];
  item_t it_c  [NC+1];
  logic [31:0] res_re, res_im;
  logic [1:0]  status;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tdata[2:0]),
    .in_a_re   (in_tdata[34:3]),
    .in_a_im   (in_tdata[66:35]),
    .in_b_re   (in_tdata[98:67]),
    .in_b_im   (in_tdata[130:99]),
    .out_valid (v_c[0]),
    .out_ready (r_c[0]),
    .out_item  (it_c[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    cau_div_cell #(.SHIFT(QB - i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_c[i]),
      .in_ready  (r_c[i]),
      .in_item   (it_c[i]),
      .out_valid (v_c[i+1]),
      .out_ready (r_c[i+1]),
      .out_item  (it_c[i+1])
    );
  end

  cau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_c[NC]),
    .in_ready  (r_c[NC]),
    .in_item   (it_c[NC]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_re    (res_re),
    .out_im    (res_im),
    .out_st    (status)
  );

  assign out_tdata = {6'd0, status, res_im, res_re};

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for complex_arithmetic_unit (add, sub, mul, div, increment).
// Uses cau_pkg for command and status codes; needs only the RTL under rtl/.
module testbench;
  import cau_pkg::*;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cplx_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;

  cplx_res_t expected_q[$];
  int        n_errors = 0;
  int        n_results = 0;
  int        n_sent = 0;
  int        cycle_count = 0;
  int        hold_cycles = 0;  // receiver forced stall length
  bit        rx_idle_en = 1'b1;
  int        gap_max = 3;

  complex_arithmetic_unit uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Saturate a wide signed value to 32 bits.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit ov);
    if (v > 128'sh7FFFFFFF) begin
      ov = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sh80000000) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // num * 2^16 / den, rounded half away from zero on the magnitude
  function automatic logic [31:0] quot_part(input logic signed [127:0] num,
                                           input logic [127:0] den, inout bit ov);
    logic [127:0] mag;
    logic [127:0] q;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = ((mag << 16) + (den >> 1)) / den;
    if (!neg && q > 128'h7FFF_FFFF) begin
      ov = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (neg && q > 128'h8000_0000) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic cplx_res_t complex_result(input logic [2:0] cmd,
      input logic signed [31:0] ar, ai, br, bi);
    cplx_res_t r;
    bit ov;
    logic signed [127:0] xr, xi, yr, yi, s_re, s_im;
    logic [127:0] den;
    ov = 1'b0;
    r = '0;
    xr = ar; xi = ai; yr = br; yi = bi;
    case (cmd)
      CMD_ADD: begin
        r.re = clamp32(xr + yr, ov);
        r.im = clamp32(xi + yi, ov);
      end
      CMD_SUB: begin
        r.re = clamp32(xr - yr, ov);
        r.im = clamp32(xi - yi, ov);
      end
      CMD_MUL: begin
        s_re = (xr * yr - xi * yi + 128'sd32768) >>> 16;
        s_im = (xr * yi + yr * xi + 128'sd32768) >>> 16;
        r.re = clamp32(s_re, ov);
        r.im = clamp32(s_im, ov);
      end
      CMD_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) r.st = ST_DZ;
        else begin
          r.re = quot_part(xr * yr + xi * yi, den, ov);
          r.im = quot_part(xi * yr - xr * yi, den, ov);
        end
      end
      CMD_INC: begin
        r.re = clamp32(xr + 128'sd65536, ov);
        r.im = clamp32(xi + 128'sd65536, ov);
      end
      default: ;
    endcase
    if (ov) r.st = ST_OV;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    n_errors++;
    $display("mismatch at result %0d: %s got %h expected %h", n_results, what, got, want);
  endtask

  // Result checker
  always @(posedge clk) begin
    cplx_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata[31:0], 32'd0);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_tdata[31:0] !== exp_r.re) report_mismatch("res_re", out_tdata[31:0], exp_r.re);
        if (out_tdata[63:32] !== exp_r.im) report_mismatch("res_im", out_tdata[63:32], exp_r.im);
        if (out_tdata[65:64] !== exp_r.st)
          report_mismatch("status", 32'(out_tdata[65:64]), 32'(exp_r.st));
      end
      n_results++;
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_idle_en) begin
      if ($urandom_range(0, 9) == 0) out_tready <= 1'b0;
      else if ($urandom_range(0, 40) == 0) out_tready <= 1'b0;
      else out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      4: return 32'($signed($urandom_range(0, 131072)) - 65536);
      5: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom();
    endcase
  endfunction

  // tvalid stays high into the next transaction when there is no gap;
  // wait_drained drops it after the last one.
  task automatic send_item(input logic [2:0] cmd, input logic [31:0] ar, ai, br, bi);
    int gap;
    gap = 0;
    if (gap_max > 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, gap_max);
      if ($urandom_range(0, 1)) gap = 0;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {5'b0, bi, br, ai, ar, cmd};
    in_tvalid <= 1'b1;
    expected_q.push_back(complex_result(cmd, ar, ai, br, bi));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_item(CMD_ADD, mx, mn, 32'd1, 32'hFFFF_FFFF);
    send_item(CMD_ADD, mx, mn, mx, mn);
    send_item(CMD_SUB, mn, mx, 32'd1, 32'hFFFF_FFFF);
    send_item(CMD_SUB, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0);
    send_item(CMD_MUL, mn, mn, mn, mn);
    send_item(CMD_MUL, mx, mx, mx, mn);
    send_item(CMD_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0);
    send_item(CMD_MUL, 32'hFFFF_8000, 32'h0, 32'h0000_0001, 32'h0);
    send_item(CMD_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
    send_item(CMD_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_item(CMD_DIV, mx, mn, 32'h0, 32'h0);
    send_item(CMD_DIV, mx, mx, 32'h0000_0001, 32'h0);
    send_item(CMD_DIV, mn, mn, mn, mn);
    send_item(CMD_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    send_item(CMD_DIV, 32'hFFFF_0000, 32'h0, 32'h0002_0000, 32'h0);
    send_item(CMD_DIV, 32'h0000_0001, 32'h0, 32'h0002_0000, 32'h0);
    send_item(CMD_DIV, mn, 32'h0, 32'h0001_0000, 32'h0);
    send_item(CMD_INC, mx, 32'hFFFF_0000, mn, mx);
    send_item(CMD_INC, mn, 32'h0, 32'h0, 32'h0);
    send_item(3'd5, mx, mx, mx, mx);
    send_item(3'd6, 32'h1, 32'h2, 32'h3, 32'h4);
    send_item(3'd7, mn, mn, mn, mn);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    logic [2:0] cmd;
    repeat (count) begin
      cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_item(cmd, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    wait_drained();
  endtask

  // Long receiver stall with the sender running flat out fills the pipeline.
  task automatic test_backpressure();
    gap_max = 0;
    @(negedge clk);
    hold_cycles = 150;
    repeat (120) send_item(3'($urandom_range(0, 4)), $urandom(), $urandom(), $urandom(), $urandom());
    gap_max = 3;
    wait_drained();
  endtask

  task automatic test_no_idle();
    gap_max = 0;
    rx_idle_en = 1'b0;
    test_random(200);
    rx_idle_en = 1'b1;
    gap_max = 3;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(800);
    test_backpressure();
    test_no_idle();
    test_random(800);
    $display("sent %0d transactions, checked %0d results", n_sent, n_results);
    $display("covered all commands, unused codes, saturation, zero divisor and stalls");
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Leftover expectations are caught by wait_drained timing out via cycle limit.
endmodule
